// ===== sv/dpd_pkg.sv =====
package dpd_pkg;

  // Default geometry and queue sizing.
  localparam int COORD_BITS  = 12;
  localparam int STRIDE_BITS = 8;
  localparam int QUEUE_DEPTH = 2;

  // Configuration port.
  localparam int CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH     = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT    = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLING_FORMAT = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PRINCIPAL_POINT = 8'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_INVERSE_FOCAL   = 8'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_TRANSFORM_X     = 8'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_TRANSFORM_Y     = 8'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_TRANSFORM_Z     = 8'd7;

  // Bit positions inside sampling_and_format.
  localparam int FMT_F32    = 8;
  localparam int FMT_BIG    = 9;
  localparam int FMT_COLOUR = 10;
  localparam int FMT_BGR    = 11;
  localparam int FMT_XFORM  = 12;

  // Millimetre to 2^-32 m conversion: floor((2^29*mm + 62) / 125) is
  // RECIP_Q*mm + floor((37*mm + 62) * RECIP_M / 2^29).
  localparam logic [22:0] RECIP_Q = 23'd4294967;
  localparam logic [22:0] RECIP_M = 23'd4294968;

  // Translation term: floor((2^26*|t| + 62) / 125) is
  // TRANS_Q*|t| + floor((TRANS_R*|t| + 62) * RECIP_M / 2^29).
  localparam int TV_W = 35;
  localparam logic [19:0] TRANS_Q = 20'd536870;
  localparam logic [6:0]  TRANS_R = 7'd114;

  localparam logic [47:0] ZF_MAX    = 48'hFFFF_FFFF_FFFF;
  localparam logic [24:0] COUNT_MAX = 25'h1FF_FFFF;

  // Registers seen by the front part.
  typedef struct packed {
    logic [12:0] frame_width;
    logic [12:0] frame_height;
    logic [12:0] fmt;
    logic [23:0] cx;
    logic [23:0] cy;
  } dpd_front_cfg_t;

  // Registers seen by the back part.
  typedef struct packed {
    logic               xform;
    logic [23:0]        inv_fx;
    logic [23:0]        inv_fy;
    logic [63:0]        row_x;
    logic [63:0]        row_y;
    logic [63:0]        row_z;
    logic signed [35:0] tv_x;
    logic signed [35:0] tv_y;
    logic signed [35:0] tv_z;
  } dpd_back_cfg_t;

  // One classified pixel travelling from front to back.
  typedef struct packed {
    logic               have;
    logic               fend;
    logic               f32;
    logic [31:0]        depth;
    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic [23:0]        rgb;
    logic [24:0]        count;
  } dpd_entry_t;

  // Clamp a wide signed value to the int32 range.
  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sh0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -48'sh0000_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/depth_pixel_deprojector_top.sv =====
// Channel  Direction  Handshake                Payload
// s        in         s_tvalid / s_tready      depth pixel and colour bytes
// m        out        m_tvalid / m_tready      point, colour, count; tlast frame end
// cfg      in         cfg_valid / cfg_ready    register index and write data
//
// A pixel that is off the stride grid or has dropped depth enters the queue only if it
// ends the frame. A kept pixel holds the back sequencer longer with millimetre depth
// than with float depth, longer still with the transform; a bare frame end is the
// shortest. The shared 24x24 multiplier and one-coefficient transform step set this.
// A transform row write starts the translation multiply in dpd_tdiv; input and
// configuration wait for it.
// Reset is synchronous and clears counters, queue, sequencer and output valid.
// The queue lets the front take pixels while the back works or the output stalls.
module depth_pixel_deprojector_top #(
  parameter int COORD_BITS  = dpd_pkg::COORD_BITS,
  parameter int STRIDE_BITS = dpd_pkg::STRIDE_BITS,
  parameter int QUEUE_DEPTH = dpd_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // depth_word[31:0], color_byte_first[39:32], color_byte_second[47:40],
  // color_byte_third[55:48]
  input  logic [55:0]                     s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // point_x[31:0], point_y[63:32], point_z[95:64], packed_rgb[119:96],
  // points_in_frame[144:120], zero[151:145]
  output logic [151:0]                    m_tdata,
  output logic                            m_tlast,
  // point_valid[0]
  output logic                            m_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dpd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]                     cfg_data
);

  logic [12:0]        frame_width, frame_height, sampling_and_format;
  logic [47:0]        principal_point, inverse_focal;
  logic [63:0]        transform_row_x, transform_row_y, transform_row_z;
  logic signed [35:0] tv_x, tv_y, tv_z;
  logic [1:0]         div_row;
  logic               div_neg;

  logic                            cfg_we, div_start, div_busy, div_done;
  logic [15:0]                     t_mag;
  logic [dpd_pkg::TV_W-1:0]        div_q;
  logic signed [35:0]              div_tv;

  dpd_pkg::dpd_front_cfg_t fcfg;
  dpd_pkg::dpd_back_cfg_t  bcfg;
  dpd_pkg::dpd_entry_t     f_entry, q_data;
  logic                    take, f_push, q_ready, q_valid, q_pop;
  logic signed [31:0]      point_x, point_y, point_z;
  logic [23:0]             packed_rgb;
  logic [24:0]             points_in_frame;

  assign cfg_ready = !div_busy;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign s_tready  = q_ready && !div_busy;
  assign take      = s_tvalid && s_tready;

  // Translation conversion is started by any transform row write.
  always_comb begin
    t_mag        = cfg_data[63] ? 16'(-cfg_data[63:48]) : cfg_data[63:48];
    div_start    = cfg_we && ((cfg_index == dpd_pkg::REG_TRANSFORM_X) ||
                              (cfg_index == dpd_pkg::REG_TRANSFORM_Y) ||
                              (cfg_index == dpd_pkg::REG_TRANSFORM_Z));
    div_tv       = div_neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width         <= 13'd640;
      frame_height        <= 13'd480;
      sampling_and_format <= 13'd1;
      principal_point     <= '0;
      inverse_focal       <= 48'd1048576;
      transform_row_x     <= 64'd8192;
      transform_row_y     <= 64'd536870912;
      transform_row_z     <= 64'd35184372088832;
      tv_x                <= '0;
      tv_y                <= '0;
      tv_z                <= '0;
      div_row             <= '0;
      div_neg             <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          dpd_pkg::REG_FRAME_WIDTH:     frame_width         <= cfg_data[12:0];
          dpd_pkg::REG_FRAME_HEIGHT:    frame_height        <= cfg_data[12:0];
          dpd_pkg::REG_SAMPLING_FORMAT: sampling_and_format <= cfg_data[12:0];
          dpd_pkg::REG_PRINCIPAL_POINT: principal_point     <= cfg_data[47:0];
          dpd_pkg::REG_INVERSE_FOCAL:   inverse_focal       <= cfg_data[47:0];
          dpd_pkg::REG_TRANSFORM_X: begin
            transform_row_x <= cfg_data;
            div_row         <= 2'd0;
          end
          dpd_pkg::REG_TRANSFORM_Y: begin
            transform_row_y <= cfg_data;
            div_row         <= 2'd1;
          end
          dpd_pkg::REG_TRANSFORM_Z: begin
            transform_row_z <= cfg_data;
            div_row         <= 2'd2;
          end
          default: begin
          end
        endcase
        div_neg <= cfg_data[63];
      end
      if (div_done) begin
        case (div_row)
          2'd0:    tv_x <= div_tv;
          2'd1:    tv_y <= div_tv;
          default: tv_z <= div_tv;
        endcase
      end
    end
  end

  always_comb begin
    fcfg.frame_width  = frame_width;
    fcfg.frame_height = frame_height;
    fcfg.fmt          = sampling_and_format;
    fcfg.cx           = principal_point[23:0];
    fcfg.cy           = principal_point[47:24];
    bcfg.xform        = sampling_and_format[dpd_pkg::FMT_XFORM];
    bcfg.inv_fx       = inverse_focal[23:0];
    bcfg.inv_fy       = inverse_focal[47:24];
    bcfg.row_x        = transform_row_x;
    bcfg.row_y        = transform_row_y;
    bcfg.row_z        = transform_row_z;
    bcfg.tv_x         = tv_x;
    bcfg.tv_y         = tv_y;
    bcfg.tv_z         = tv_z;
  end

  dpd_tdiv u_tdiv (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .magnitude (t_mag),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_q)
  );

  dpd_front #(
    .COORD_BITS  (COORD_BITS),
    .STRIDE_BITS (STRIDE_BITS)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .cfg               (fcfg),
    .take              (take),
    .depth_word        (s_tdata[31:0]),
    .color_byte_first  (s_tdata[39:32]),
    .color_byte_second (s_tdata[47:40]),
    .color_byte_third  (s_tdata[55:48]),
    .push              (f_push),
    .entry             (f_entry)
  );

  dpd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .push_data (f_entry),
    .ready     (q_ready),
    .pop       (q_pop),
    .valid     (q_valid),
    .data      (q_data)
  );

  dpd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (bcfg),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .q_pop           (q_pop),
    .m_valid         (m_tvalid),
    .m_ready         (m_tready),
    .point_x         (point_x),
    .point_y         (point_y),
    .point_z         (point_z),
    .packed_rgb      (packed_rgb),
    .point_valid     (m_tuser),
    .frame_end       (m_tlast),
    .points_in_frame (points_in_frame)
  );

  assign m_tdata = {7'h00, points_in_frame, packed_rgb, point_z, point_y, point_x};

endmodule

// ===== sv/dpd_fifo.sv =====
module dpd_fifo #(
  parameter int DEPTH = dpd_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  dpd_pkg::dpd_entry_t push_data,
  output logic                ready,
  input  logic                pop,
  output logic                valid,
  output dpd_pkg::dpd_entry_t data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  dpd_pkg::dpd_entry_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign ready = count != CW'(DEPTH);
  assign valid = count != '0;
  assign data  = mem[rd_ptr];

  // Storage is written at the tail only.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/dpd_tdiv.sv =====
module dpd_tdiv (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [15:0]                  magnitude,
  output logic                         busy,
  output logic                         done,
  output logic [dpd_pkg::TV_W-1:0]     quotient
);

  logic        stage1;
  logic        stage2;
  logic [35:0] base;
  logic [21:0] rem_term;
  logic [44:0] frac_prod;

  // Remainder part of the quotient by reciprocal multiplication.
  assign frac_prod = 45'(rem_term) * 45'(dpd_pkg::RECIP_M);

  assign busy = stage1 || stage2;
  assign done = stage2;

  // Two-stage pipeline flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage1 <= 1'b0;
      stage2 <= 1'b0;
    end else begin
      stage1 <= start;
      stage2 <= stage1;
    end
  end

  // First stage splits the dividend, second stage forms the quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      base     <= 36'(magnitude) * 36'(dpd_pkg::TRANS_Q);
      rem_term <= 22'(magnitude) * 22'(dpd_pkg::TRANS_R) + 22'd62;
    end
    if (stage1) begin
      quotient <= dpd_pkg::TV_W'(base + 36'(frac_prod[44:29]));
    end
  end

endmodule

// ===== sv/dpd_front.sv =====
module dpd_front #(
  parameter int COORD_BITS  = dpd_pkg::COORD_BITS,
  parameter int STRIDE_BITS = dpd_pkg::STRIDE_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  dpd_pkg::dpd_front_cfg_t cfg,
  input  logic                    take,
  input  logic [31:0]             depth_word,
  input  logic [7:0]              color_byte_first,
  input  logic [7:0]              color_byte_second,
  input  logic [7:0]              color_byte_third,
  output logic                    push,
  output dpd_pkg::dpd_entry_t     entry
);

  localparam int SZW = (COORD_BITS + 1 > 13) ? COORD_BITS + 1 : 13;
  localparam logic [SZW-1:0] SIZE_LIM = SZW'(2 ** COORD_BITS);

  logic [COORD_BITS-1:0]  column_counter;
  logic [COORD_BITS-1:0]  row_counter;
  logic [STRIDE_BITS-1:0] column_phase;
  logic [STRIDE_BITS-1:0] row_phase;
  logic [24:0]            point_counter;

  logic [SZW-1:0]         w_eff, h_eff;
  logic                   last_col, last_row, fend;
  logic [STRIDE_BITS-1:0] stride;
  logic [STRIDE_BITS:0]   col_ph_inc, row_ph_inc;
  logic [15:0]            mm;
  logic [31:0]            fbits;
  logic                   f32, big, depth_ok, keep;
  logic [24:0]            count_inc;
  logic [23:0]            rgb;

  // Effective frame size and end-of-row and end-of-frame detection.
  always_comb begin
    w_eff = (cfg.frame_width == '0) ? SZW'(1) :
            ((SZW'(cfg.frame_width) > SIZE_LIM) ? SIZE_LIM : SZW'(cfg.frame_width));
    h_eff = (cfg.frame_height == '0) ? SZW'(1) :
            ((SZW'(cfg.frame_height) > SIZE_LIM) ? SIZE_LIM : SZW'(cfg.frame_height));
    last_col = SZW'(column_counter) >= w_eff - 1'b1;
    last_row = SZW'(row_counter) >= h_eff - 1'b1;
    fend     = last_col && last_row;
  end

  // Stride phases.
  always_comb begin
    stride     = (cfg.fmt[STRIDE_BITS-1:0] == '0) ? STRIDE_BITS'(1) :
                 cfg.fmt[STRIDE_BITS-1:0];
    col_ph_inc = {1'b0, column_phase} + 1'b1;
    row_ph_inc = {1'b0, row_phase} + 1'b1;
  end

  // Depth byte order and the drop rules.
  always_comb begin
    f32   = cfg.fmt[dpd_pkg::FMT_F32];
    big   = cfg.fmt[dpd_pkg::FMT_BIG];
    mm    = big ? {depth_word[7:0], depth_word[15:8]} : depth_word[15:0];
    fbits = big ? {depth_word[7:0], depth_word[15:8], depth_word[23:16], depth_word[31:24]}
                : depth_word;
    if (f32) begin
      depth_ok = !(fbits[31] || (fbits[30:23] == 8'hFF) ||
                   ((fbits[30:23] == 8'h00) && (fbits[22:0] == '0)));
    end else begin
      depth_ok = mm != '0;
    end
    keep = (column_phase == '0) && (row_phase == '0) && depth_ok;
  end

  // Colour packing and point count.
  always_comb begin
    if (keep && cfg.fmt[dpd_pkg::FMT_COLOUR]) begin
      rgb = cfg.fmt[dpd_pkg::FMT_BGR] ?
            {color_byte_third, color_byte_second, color_byte_first} :
            {color_byte_first, color_byte_second, color_byte_third};
    end else begin
      rgb = '0;
    end
    count_inc = (keep && (point_counter != dpd_pkg::COUNT_MAX)) ?
                point_counter + 1'b1 : point_counter;
  end

  // Queue entry.
  always_comb begin
    entry.have  = keep;
    entry.fend  = fend;
    entry.f32   = f32;
    entry.depth = f32 ? fbits : {16'h0000, mm};
    entry.dx    = $signed(25'({column_counter, 8'h00}) - {1'b0, cfg.cx});
    entry.dy    = $signed(25'({row_counter, 8'h00}) - {1'b0, cfg.cy});
    entry.rgb   = rgb;
    entry.count = count_inc;
  end

  assign push = take && (keep || fend);

  // Raster position and phases advance on every accepted pixel; the point count on kept ones.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_counter <= '0;
      row_counter    <= '0;
      column_phase   <= '0;
      row_phase      <= '0;
      point_counter  <= '0;
    end else if (take) begin
      point_counter <= fend ? '0 : count_inc;
      if (last_col) begin
        column_counter <= '0;
        column_phase   <= '0;
        if (last_row) begin
          row_counter <= '0;
          row_phase   <= '0;
        end else begin
          row_counter <= row_counter + 1'b1;
          row_phase   <= (row_ph_inc >= {1'b0, stride}) ? '0 : row_ph_inc[STRIDE_BITS-1:0];
        end
      end else begin
        column_counter <= column_counter + 1'b1;
        column_phase   <= (col_ph_inc >= {1'b0, stride}) ? '0 : col_ph_inc[STRIDE_BITS-1:0];
      end
    end
  end

endmodule

// ===== sv/dpd_back.sv =====
module dpd_back (
  input  logic                   clk,
  input  logic                   rst,
  input  dpd_pkg::dpd_back_cfg_t cfg,
  input  logic                   q_valid,
  input  dpd_pkg::dpd_entry_t    q_data,
  output logic                   q_pop,
  output logic                   m_valid,
  input  logic                   m_ready,
  output logic signed [31:0]     point_x,
  output logic signed [31:0]     point_y,
  output logic signed [31:0]     point_z,
  output logic [23:0]            packed_rgb,
  output logic                   point_valid,
  output logic                   frame_end,
  output logic [24:0]            points_in_frame
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DEC1 = 4'd1;
  localparam logic [3:0] ST_DEC2 = 4'd2;
  localparam logic [3:0] ST_DEC3 = 4'd3;
  localparam logic [3:0] ST_RAY  = 4'd4;
  localparam logic [3:0] ST_RFIN = 4'd5;
  localparam logic [3:0] ST_XF   = 4'd6;
  localparam logic [3:0] ST_XFIN = 4'd7;
  localparam logic [3:0] ST_OUT  = 4'd8;

  logic [3:0]          state;
  dpd_pkg::dpd_entry_t cur;
  logic [47:0]         pa, pb, zf, a_reg;
  logic [21:0]         x_r;
  logic [95:0]         acc;
  logic [2:0]          step;
  logic                axis;
  logic signed [41:0]  xc, yc;
  logic [1:0]          xrow, xcol;
  logic signed [59:0]  acc_t;
  logic signed [31:0]  px, py, pz;

  logic [23:0]         ma, mb;
  logic [47:0]         prod;
  logic [95:0]         partial;
  logic signed [24:0]  dsel;
  logic                dneg;
  logic [24:0]         dmag;
  logic [7:0]          fe;
  logic [23:0]         fm;
  logic signed [9:0]   fs;
  logic [9:0]          fk;
  logic [40:0]         frnd;
  logic [47:0]         zf_float;
  logic [21:0]         x_next;
  logic [48:0]         zc_sum;
  logic signed [41:0]  zc;
  logic [51:0]         rsh;
  logic [40:0]         rlim;
  logic signed [41:0]  rval;
  logic [63:0]         rowv;
  logic signed [15:0]  coef;
  logic signed [41:0]  csel;
  logic signed [57:0]  tprod;
  logic [59:0]         tmag;
  logic [46:0]         trnd;
  logic signed [47:0]  tres;
  logic signed [35:0]  tv_next;
  logic                load_out;

  // Float depth to 2^-32 m, rounded half up, saturated.
  always_comb begin
    fe   = cur.depth[30:23];
    fm   = (fe == 8'h00) ? {1'b0, cur.depth[22:0]} : {1'b1, cur.depth[22:0]};
    fs   = $signed({2'b00, (fe == 8'h00) ? 8'd1 : fe}) - 10'sd118;
    fk   = 10'(-fs);
    frnd = 41'(fm) + (41'(1) << (fk[5:0] - 6'd1));
    if (fs > 10'sd24) begin
      zf_float = dpd_pkg::ZF_MAX;
    end else if (fs >= 10'sd0) begin
      zf_float = 48'(fm) << fs[4:0];
    end else if (fk > 10'd40) begin
      zf_float = '0;
    end else begin
      zf_float = 48'(frnd >> fk[5:0]);
    end
    x_next = 22'(({6'b0, cur.depth[15:0]} << 5) + ({6'b0, cur.depth[15:0]} << 2) +
                 {6'b0, cur.depth[15:0]} + 22'd62);
  end

  // Ray offset of the axis in work.
  always_comb begin
    dsel = axis ? cur.dy : cur.dx;
    dneg = dsel[24];
    dmag = dneg ? 25'(-dsel) : 25'(dsel);
  end

  // Shared 24 by 24 multiplier.
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      ST_DEC1: begin
        ma = {8'h00, cur.depth[15:0]};
        mb = {1'b0, dpd_pkg::RECIP_Q};
      end
      ST_DEC2: begin
        ma = {2'b00, x_r};
        mb = {1'b0, dpd_pkg::RECIP_M};
      end
      ST_RAY: begin
        case (step)
          3'd0: begin
            ma = dmag[23:0];
            mb = axis ? cfg.inv_fy : cfg.inv_fx;
          end
          3'd1: begin ma = a_reg[23:0];  mb = zf[23:0];  end
          3'd2: begin ma = a_reg[23:0];  mb = zf[47:24]; end
          3'd3: begin ma = a_reg[47:24]; mb = zf[23:0];  end
          default: begin ma = a_reg[47:24]; mb = zf[47:24]; end
        endcase
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    prod = ma * mb;
    case (step)
      3'd1:    partial = {48'h0, prod};
      3'd2:    partial = {48'h0, prod} << 24;
      3'd3:    partial = {48'h0, prod} << 24;
      default: partial = {48'h0, prod} << 48;
    endcase
  end

  // Ray result rounding and saturation, depth in 2^-16 m.
  always_comb begin
    rsh    = acc[95:44];
    rlim   = (rsh > (52'(1) << 40)) ? (41'(1) << 40) : rsh[40:0];
    rval   = dneg ? -$signed({1'b0, rlim}) : $signed({1'b0, rlim});
    zc_sum = {1'b0, zf} + 49'h8000;
    zc     = $signed({9'h000, zc_sum[48:16]});
  end

  // Transform step: one coefficient times one camera coordinate.
  always_comb begin
    case (xrow)
      2'd0:    rowv = cfg.row_x;
      2'd1:    rowv = cfg.row_y;
      default: rowv = cfg.row_z;
    endcase
    case (xcol)
      2'd0: begin coef = $signed(rowv[15:0]);  csel = xc; end
      2'd1: begin coef = $signed(rowv[31:16]); csel = yc; end
      default: begin coef = $signed(rowv[47:32]); csel = zc; end
    endcase
    tprod = coef * csel;
    tmag  = acc_t[59] ? 60'(-acc_t) : 60'(acc_t);
    trnd  = 47'((tmag + 60'd4096) >> 13);
    tres  = acc_t[59] ? -$signed({1'b0, trnd}) : $signed({1'b0, trnd});
    case (xrow)
      2'd0:    tv_next = cfg.tv_y;
      default: tv_next = cfg.tv_z;
    endcase
  end

  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign load_out = (state == ST_OUT) && (!m_valid || m_ready);

  // Sequencer for one point.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
      axis  <= 1'b0;
      xrow  <= '0;
      xcol  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            axis  <= 1'b0;
            step  <= '0;
            state <= q_data.have ? ST_DEC1 : ST_OUT;
          end
        end
        ST_DEC1: state <= cur.f32 ? ST_RAY : ST_DEC2;
        ST_DEC2: state <= ST_DEC3;
        ST_DEC3: state <= ST_RAY;
        ST_RAY: begin
          if (step == 3'd4) begin
            step  <= '0;
            state <= ST_RFIN;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_RFIN: begin
          axis <= !axis;
          if (!axis) begin
            state <= ST_RAY;
          end else if (cfg.xform) begin
            xrow  <= '0;
            xcol  <= '0;
            state <= ST_XF;
          end else begin
            state <= ST_OUT;
          end
        end
        ST_XF: begin
          if (xcol == 2'd2) begin
            state <= ST_XFIN;
          end else begin
            xcol <= xcol + 1'b1;
          end
        end
        ST_XFIN: begin
          xcol <= '0;
          if (xrow == 2'd2) begin
            state <= ST_OUT;
          end else begin
            xrow  <= xrow + 1'b1;
            state <= ST_XF;
          end
        end
        ST_OUT: begin
          if (!m_valid || m_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Arithmetic registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
      px  <= '0;
      py  <= '0;
      pz  <= '0;
    end
    if (state == ST_DEC1) begin
      zf  <= zf_float;
      pa  <= prod;
      x_r <= x_next;
    end
    if (state == ST_DEC2) begin
      pb <= prod;
    end
    if (state == ST_DEC3) begin
      zf <= pa + 48'(pb >> 29);
    end
    if (state == ST_RAY) begin
      if (step == 3'd0) begin
        a_reg <= prod;
        acc   <= 96'(1) << 43;
      end else begin
        acc <= acc + partial;
      end
    end
    if (state == ST_RFIN) begin
      if (!axis) begin
        xc <= rval;
      end else begin
        yc    <= rval;
        acc_t <= 60'(cfg.tv_x);
        px    <= dpd_pkg::sat32(48'(xc));
        py    <= dpd_pkg::sat32(48'(rval));
        pz    <= dpd_pkg::sat32(48'(zc));
      end
    end
    if (state == ST_XF) begin
      acc_t <= acc_t + 60'(tprod);
    end
    if (state == ST_XFIN) begin
      acc_t <= 60'(tv_next);
      case (xrow)
        2'd0:    px <= dpd_pkg::sat32(tres);
        2'd1:    py <= dpd_pkg::sat32(tres);
        default: pz <= dpd_pkg::sat32(tres);
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (load_out) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      point_x         <= px;
      point_y         <= py;
      point_z         <= pz;
      packed_rgb      <= cur.rgb;
      point_valid     <= cur.have;
      frame_end       <= cur.fend;
      points_in_frame <= cur.count;
    end
  end

  // A result without a point carries zero coordinates and colour.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_valid && !point_valid |-> point_x == 0 && point_y == 0 && point_z == 0 &&
                                packed_rgb == '0)
    else $error("empty result carries data");

  // Every result is a point or a frame end.
  a_has_reason: assert property (@(posedge clk) disable iff (rst)
    m_valid |-> point_valid || frame_end)
    else $error("result with no point and no frame end");

  // A point result always counts at least itself.
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_valid && point_valid |-> points_in_frame != '0)
    else $error("point with zero count");

  // The queue is only drained between points.
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state != ST_IDLE)
    else $error("sequencer did not leave idle after taking an entry");

endmodule

// ===== sim/depth_pixel_deprojector_top_tb.sv =====
`timescale 1ns / 1ps

module depth_pixel_deprojector_top_tb;
  import dpd_pkg::*;

  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 150;
  localparam int CYCLE_LIMIT     = 2000000;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [23:0] rgb;
    logic [24:0] count;
    logic        pvalid;
    logic        fend;
  } point_rec_t;

  // Predicts the point cloud output and checks what the block delivers.
  class point_scoreboard;
    logic [12:0] width_reg, height_reg, fmt;
    logic [47:0] centre, inv_focal;
    logic [63:0] rows [3];
    int          col, row, col_ph, row_ph;
    logic [24:0] count;
    point_rec_t  expected_q [$];
    int          errors;

    function new();
      width_reg = 13'd640; height_reg = 13'd480; fmt = 13'd1;
      centre = '0; inv_focal = 48'd1048576;
      rows[0] = 64'd8192; rows[1] = 64'd536870912; rows[2] = 64'd35184372088832;
      col = 0; row = 0; col_ph = 0; row_ph = 0; count = '0; errors = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [63:0] v);
      case (idx)
        REG_FRAME_WIDTH:     width_reg = v[12:0];
        REG_FRAME_HEIGHT:    height_reg = v[12:0];
        REG_SAMPLING_FORMAT: fmt = v[12:0];
        REG_PRINCIPAL_POINT: centre = v[47:0];
        REG_INVERSE_FOCAL:   inv_focal = v[47:0];
        REG_TRANSFORM_X:     rows[0] = v;
        REG_TRANSFORM_Y:     rows[1] = v;
        REG_TRANSFORM_Z:     rows[2] = v;
        default: ;
      endcase
    endfunction

    // Depth in units of 2^-32 m; returns 0 when the pixel's depth is dropped.
    function bit depth_to_zf(logic [31:0] w, output logic [63:0] zf);
      logic [63:0] mm, m;
      logic [31:0] bits;
      logic [7:0]  e;
      logic [22:0] frac;
      int          s, k;
      zf = '0;
      if (!fmt[FMT_F32]) begin
        mm = fmt[FMT_BIG] ? {48'd0, w[7:0], w[15:8]} : {48'd0, w[15:8], w[7:0]};
        if (mm == 0) return 0;
        zf = ((mm << 32) + 64'd500) / 64'd1000;
        return 1;
      end
      bits = fmt[FMT_BIG] ? {w[7:0], w[15:8], w[23:16], w[31:24]} : w;
      e = bits[30:23];
      frac = bits[22:0];
      if (bits[31] || e == 8'hFF || (e == 0 && frac == 0)) return 0;
      m = (e == 0) ? {41'd0, frac} : {40'd0, 1'b1, frac};
      s = ((e == 0) ? 1 : int'(e)) - 118;
      if (s > 24) zf = {16'd0, ZF_MAX};
      else if (s >= 0) zf = m << s;
      else if (-s > 40) zf = '0;
      else begin
        k = -s;
        zf = (m + (64'd1 << (k - 1))) >> k;
      end
      return 1;
    endfunction

    // Offset times inverse focal length times depth, rounded, limited to 2^40.
    function longint ray_scale(longint d, logic [23:0] inv, logic [63:0] zf);
      logic [127:0] mag, p;
      longint       v;
      mag = (d < 0) ? 128'(-d) : 128'(d);
      p = (mag * 128'(inv) * 128'(zf) + (128'd1 << 43)) >> 44;
      if (p > (128'd1 << 40)) p = 128'd1 << 40;
      v = longint'(p[63:0]);
      return (d < 0) ? -v : v;
    endfunction

    function longint rigid_row(logic [63:0] r, longint x, longint y, longint z);
      longint acc, tm, tv, mag;
      acc = longint'($signed(r[15:0])) * x + longint'($signed(r[31:16])) * y +
            longint'($signed(r[47:32])) * z;
      tm = longint'($signed(r[63:48]));
      tv = (((tm < 0 ? -tm : tm) << 29) + 500) / 1000;
      acc += (tm < 0) ? -tv : tv;
      mag = ((acc < 0 ? -acc : acc) + (64'sd1 << 12)) >>> 13;
      return (acc < 0) ? -mag : mag;
    endfunction

    function logic [31:0] clamp32(longint v);
      if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
      if (v < -64'sh8000_0000) return 32'h8000_0000;
      return v[31:0];
    endfunction

    function int frame_size(logic [12:0] r);
      if (r == 0) return 1;
      return (r > (1 << COORD_BITS)) ? (1 << COORD_BITS) : int'(r);
    endfunction

    // Advances the raster position for one accepted pixel and queues its result.
    function void note_pixel(logic [55:0] d);
      int          stride, w, h;
      bit          last_col, last_row, kept;
      logic [63:0] zf;
      longint      xc, yc, zc, dx, dy;
      point_rec_t  r;
      stride = (fmt[7:0] < 1) ? 1 : int'(fmt[7:0]);
      w = frame_size(width_reg);
      h = frame_size(height_reg);
      last_col = col >= w - 1;
      last_row = row >= h - 1;
      r = '0;
      kept = 0;
      if (col_ph == 0 && row_ph == 0 && depth_to_zf(d[31:0], zf)) begin
        dx = longint'(col) * 256 - longint'(centre[23:0]);
        dy = longint'(row) * 256 - longint'(centre[47:24]);
        xc = ray_scale(dx, inv_focal[23:0], zf);
        yc = ray_scale(dy, inv_focal[47:24], zf);
        zc = longint'((zf + 64'h8000) >> 16);
        if (fmt[FMT_XFORM]) begin
          r.x = clamp32(rigid_row(rows[0], xc, yc, zc));
          r.y = clamp32(rigid_row(rows[1], xc, yc, zc));
          r.z = clamp32(rigid_row(rows[2], xc, yc, zc));
        end else begin
          r.x = clamp32(xc); r.y = clamp32(yc); r.z = clamp32(zc);
        end
        if (fmt[FMT_COLOUR])
          r.rgb = fmt[FMT_BGR] ? {d[55:48], d[47:40], d[39:32]}
                               : {d[39:32], d[47:40], d[55:48]};
        kept = 1;
        if (count != COUNT_MAX) count++;
      end
      if (last_col) begin
        col = 0; col_ph = 0;
        if (last_row) begin
          row = 0; row_ph = 0;
        end else begin
          row++;
          row_ph = (row_ph + 1 >= stride) ? 0 : row_ph + 1;
        end
      end else begin
        col++;
        col_ph = (col_ph + 1 >= stride) ? 0 : col_ph + 1;
      end
      if (kept || (last_col && last_row)) begin
        r.pvalid = kept;
        r.fend = last_col && last_row;
        r.count = count;
        expected_q = {expected_q, r};
        if (r.fend) count = '0;
      end
    endfunction

    function void compare(string name, logic [31:0] e, logic [31:0] g);
      if (e !== g) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, e, g);
        errors++;
      end
    endfunction

    function void check_point(point_rec_t got);
      point_rec_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected point, got %h", $time, got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      compare("point_x", e.x, got.x);
      compare("point_y", e.y, got.y);
      compare("point_z", e.z, got.z);
      compare("packed_rgb", 32'(e.rgb), 32'(got.rgb));
      compare("points_in_frame", 32'(e.count), 32'(got.count));
      compare("point_valid", 32'(e.pvalid), 32'(got.pvalid));
      compare("frame_end", 32'(e.fend), 32'(got.fend));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [55:0]            s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [151:0]           m_tdata;
  logic                   m_tlast;
  logic                   m_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [63:0]            cfg_data = '0;

  point_scoreboard sb = new();
  int send_gap  = 0;
  int recv_stall = 0;
  bit hold_req  = 0;
  int hold_left = 0;
  int cycles    = 0;

  depth_pixel_deprojector_top DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("depth_pixel_deprojector_top test failed");
      $finish;
    end
  end

  // Receiver readiness: random stalls, or one long hold-off on request.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_left <= HOLD_OFF_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // Accepted results go straight to the scoreboard.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_point('{x: m_tdata[31:0], y: m_tdata[63:32], z: m_tdata[95:64],
                       rgb: m_tdata[119:96], count: m_tdata[144:120],
                       pvalid: m_tuser, fend: m_tlast});
  end

  task automatic send_pixel(input logic [55:0] d);
    @(negedge clk);
    while ($urandom_range(99) < send_gap) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
    sb.note_pixel(d);
  endtask

  task automatic end_burst();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  // Waits for outstanding points, then lets any in-flight work drain.
  task automatic wait_idle();
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, v);
  endtask

  task automatic write_all(input logic [12:0] w, input logic [12:0] h,
                           input logic [12:0] f, input logic [47:0] pp,
                           input logic [47:0] inv, input logic [63:0] rx,
                           input logic [63:0] ry, input logic [63:0] rz);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    write_reg(REG_FRAME_WIDTH, {junk[63:13], w});
    write_reg(REG_FRAME_HEIGHT, {junk[63:13], h});
    write_reg(REG_SAMPLING_FORMAT, {junk[63:13], f});
    write_reg(REG_PRINCIPAL_POINT, {junk[63:48], pp});
    write_reg(REG_INVERSE_FOCAL, {junk[63:48], inv});
    write_reg(REG_TRANSFORM_X, rx);
    write_reg(REG_TRANSFORM_Y, ry);
    write_reg(REG_TRANSFORM_Z, rz);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] random_row(int axis);
    logic [63:0] r;
    r = {$urandom, $urandom};
    if ($urandom_range(1)) begin
      // Near-rotation: small entries plus a strong diagonal.
      r[15:0]  = 16'($signed($urandom_range(0, 2000)) - 1000);
      r[31:16] = 16'($signed($urandom_range(0, 2000)) - 1000);
      r[47:32] = 16'($signed($urandom_range(0, 2000)) - 1000);
      r[16*axis +: 16] = 16'd8192 - 16'($urandom_range(0, 500));
    end
    return r;
  endfunction

  task automatic random_config();
    logic [12:0] f;
    logic [47:0] pp, inv;
    f = 13'($urandom);
    case ($urandom_range(5))
      0: f[7:0] = 8'd0;
      1, 2: f[7:0] = 8'd1;
      3: f[7:0] = 8'd2;
      4: f[7:0] = 8'd3;
      default: ;
    endcase
    if ($urandom_range(3) == 0) begin
      pp = 48'({$urandom, $urandom});
      inv = 48'({$urandom, $urandom});
    end else begin
      pp = {24'($urandom_range(0, 6 * 256)), 24'($urandom_range(0, 12 * 256))};
      inv = {24'($urandom_range(1, 8000)), 24'($urandom_range(1, 8000))};
    end
    write_all(13'($urandom_range(1, 12)), 13'($urandom_range(1, 6)), f, pp, inv,
              random_row(0), random_row(1), random_row(2));
  endtask

  // A depth word matching the current format most of the time, noise otherwise.
  function automatic logic [31:0] random_depth();
    logic [31:0] v;
    v = $urandom;
    if ($urandom_range(9) == 0) return v;
    if (!sb.fmt[FMT_F32]) begin
      if ($urandom_range(15) == 0) v[15:0] = '0;
    end else begin
      case ($urandom_range(9))
        0: v = '0;
        1: v[31] = 1'b1;
        2: v[30:23] = 8'hFF;
        3: v[30:23] = 8'h00;
        default: begin
          v[31] = 1'b0;
          v[30:23] = 8'($urandom_range(110, 150));
        end
      endcase
    end
    if (sb.fmt[FMT_BIG]) v = {v[7:0], v[15:8], v[23:16], v[31:24]};
    return v;
  endfunction

  task automatic random_burst(input int n);
    for (int i = 0; i < n; i++)
      send_pixel({8'($urandom), 8'($urandom), 8'($urandom), random_depth()});
    end_burst();
  endtask

  function automatic void set_idling(input int phase);
    case (phase % 4)
      0: begin send_gap = 0;  recv_stall = 0;  end
      1: begin send_gap = 85; recv_stall = 0;  end
      2: begin send_gap = 0;  recv_stall = 85; end
      default: begin send_gap = 12; recv_stall = 12; end
    endcase
  endfunction

  logic [31:0] mm_words [] = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                               32'h1234_0000, 32'h0000_03E8, 32'h0000_8000,
                               32'hABCD_0000, 32'h0000_00FF, 32'h0000_7FFF,
                               32'h0000_FFFE, 32'h0000_0BB8, 32'h5555_0000};
  logic [31:0] float_words [] = '{32'h0000_0000, 32'h8000_0000, 32'hBF80_0000,
                                  32'h7F80_0000, 32'h7FC0_0000, 32'h0000_0001,
                                  32'h007F_FFFF, 32'h7F7F_FFFF, 32'h3F80_0000,
                                  32'h3A83_126F, 32'h4120_0000};

  initial begin
    set_idling(0);
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Millimetre depths on a 5x2 frame, colour on, no transform.
    write_all(13'd5, 13'd2, 13'h401, 48'h000200_000180, 48'h000800_000800,
              64'd8192, 64'd536870912, 64'd35184372088832);
    foreach (mm_words[i])
      send_pixel({8'($urandom), 8'($urandom), 8'($urandom), mm_words[i]});
    end_burst();
    wait_idle();

    // Float depths on a 3x3 frame with transform and blue-first colour.
    write_all(13'd3, 13'd3, 13'h1D01, 48'h000100_000100, 48'h001000_001000,
              64'h0064_0000_0000_2000, 64'hFF9C_0000_2000_0000,
              64'h0000_2000_0000_0000);
    foreach (float_words[i])
      send_pixel({8'hA5, 8'h5A, 8'hC3, float_words[i]});
    end_burst();
    wait_idle();

    // Random settings, each phase under its own idling pattern.
    for (int p = 0; p < 12; p++) begin
      random_config();
      set_idling(p);
      if (p == 4) hold_req = 1;
      random_burst(100);
      wait_idle();
    end

    // Extremes: zero sizes, widest stride and every register bit set.
    write_all(13'd0, 13'd0, 13'h1FFF, {48{1'b1}}, {48{1'b1}},
              {64{1'b1}}, {64{1'b1}}, {64{1'b1}});
    set_idling(3);
    random_burst(40);
    wait_idle();
    write_all(13'h1FFF, 13'h1FFF, 13'h1F00, '0, '0, '0, '0, '0);
    random_burst(40);
    wait_idle();

    // Oversized width clamps to the counter range; the row runs on without wrapping.
    write_all(13'h1FFF, 13'd1, 13'h0401, 48'h080000_080000, 48'h000400_000400,
              64'd8192, 64'd536870912, 64'd35184372088832);
    set_idling(0);
    random_burst(200);
    wait_idle();

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("depth_pixel_deprojector_top test passed");
    end else begin
      $display("depth_pixel_deprojector_top test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/dpd_pkg.sv
sv/dpd_fifo.sv
sv/dpd_tdiv.sv
sv/dpd_front.sv
sv/dpd_back.sv
sv/depth_pixel_deprojector_top.sv
sim/depth_pixel_deprojector_top_tb.sv
